### sv/hsvled_pkg.sv
`default_nettype none

package hsvled_pkg;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned DUTY_W  = 16;
    localparam int unsigned SLOTS   = 24;
    localparam int unsigned SLOT_W  = 5;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_ONE_DUTY  = 1'b0,
        REG_ZERO_DUTY = 1'b1
    } t_reg_idx;

    // One colour in send order: green, red, blue
    typedef struct packed {
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] b;
    } t_grb;

    // Serialiser status seen by the top level
    typedef struct packed {
        logic              busy;
        logic [SLOT_W-1:0] cnt;
    } t_back_stat;

endpackage

`default_nettype wire

### sv/hsvled_in_if.sv
`default_nettype none

interface hsvled_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

### sv/hsvled_out_if.sv
`default_nettype none

interface hsvled_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pulse_width;
    logic        bit_value;
    logic        last_slot;

    modport source (output valid, output pulse_width, output bit_value, output last_slot,
                    input ready);
    modport sink   (input valid, input pulse_width, input bit_value, input last_slot,
                    output ready);
endinterface

`default_nettype wire

### sv/hsvled_front.sv
`default_nettype none

module hsvled_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    hsvled_in_if.sink         i_hsv,
    output logic              o_valid,
    input  wire               i_ready,
    output hsvled_pkg::t_grb  o_grb
);
    import hsvled_pkg::*;

    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } t_sector;

    localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(359);
    localparam logic [5:0]       SPAN    = 6'd60;

    // floor(x / 60) for x <= 255 * 60: drop two bits, then divide by 15
    // through the reciprocal 4370 / 65536
    function automatic logic [CH_W-1:0] div60(input logic [13:0] x);
        logic [24:0] p;
        p = 25'(x[13:2]) * 25'd4370;
        return p[23:16];
    endfunction

    // Stage A: clamp, sector, offset in sector, base level
    logic              r_a_v;
    t_sector           r_a_sec;
    logic [5:0]        r_a_f;
    logic [CH_W-1:0]   r_a_base;
    logic [CH_W-1:0]   r_a_val;
    logic              r_a_grey;
    // Stage B: ramp products
    logic              r_b_v;
    t_sector           r_b_sec;
    logic [13:0]       r_b_up;
    logic [13:0]       r_b_dn;
    logic [CH_W-1:0]   r_b_base;
    logic [CH_W-1:0]   r_b_val;
    logic              r_b_grey;
    // Stage C: finished colour
    logic              r_c_v;
    t_grb              r_c_grb;

    logic              rdy_a, rdy_b, rdy_c;
    logic [HUE_W-1:0]  hc;
    t_sector           sec;
    logic [HUE_W-1:0]  sec_start;
    logic [HUE_W-1:0]  f_full;
    logic [15:0]       base_full;
    logic [CH_W-1:0]   d;
    logic [CH_W-1:0]   up_lvl, dn_lvl;
    t_grb              grb;

    assign rdy_c       = !r_c_v || i_ready;
    assign rdy_b       = !r_b_v || rdy_c;
    assign rdy_a       = !r_a_v || rdy_b;
    assign i_hsv.ready = rdy_a;
    assign o_valid     = r_c_v;
    assign o_grb       = r_c_grb;

    always_comb begin
        hc = (i_hsv.hue > HUE_MAX) ? HUE_MAX : i_hsv.hue;
        if (hc >= HUE_W'(300)) begin
            sec = SEC_MAG_RED;
        end else if (hc >= HUE_W'(240)) begin
            sec = SEC_BLU_MAG;
        end else if (hc >= HUE_W'(180)) begin
            sec = SEC_CYN_BLU;
        end else if (hc >= HUE_W'(120)) begin
            sec = SEC_GRN_CYN;
        end else if (hc >= HUE_W'(60)) begin
            sec = SEC_YEL_GRN;
        end else begin
            sec = SEC_RED_YEL;
        end
        case (sec)
            SEC_RED_YEL: sec_start = HUE_W'(0);
            SEC_YEL_GRN: sec_start = HUE_W'(60);
            SEC_GRN_CYN: sec_start = HUE_W'(120);
            SEC_CYN_BLU: sec_start = HUE_W'(180);
            SEC_BLU_MAG: sec_start = HUE_W'(240);
            default:     sec_start = HUE_W'(300);
        endcase
        f_full    = hc - sec_start;
        base_full = 16'(8'd255 - i_hsv.saturation) * 16'(i_hsv.brightness);
    end

    always_comb begin
        d = r_a_val - r_a_base;
    end

    always_comb begin
        up_lvl = div60(r_b_up) + r_b_base;
        dn_lvl = div60(r_b_dn) + r_b_base;
        case (r_b_sec)
            SEC_RED_YEL: grb = '{g: up_lvl,   r: r_b_val,  b: r_b_base};
            SEC_YEL_GRN: grb = '{g: r_b_val,  r: dn_lvl,   b: r_b_base};
            SEC_GRN_CYN: grb = '{g: r_b_val,  r: r_b_base, b: up_lvl};
            SEC_CYN_BLU: grb = '{g: dn_lvl,   r: r_b_base, b: r_b_val};
            SEC_BLU_MAG: grb = '{g: r_b_base, r: up_lvl,   b: r_b_val};
            default:     grb = '{g: r_b_base, r: r_b_val,  b: dn_lvl};
        endcase
        if (r_b_grey) begin
            grb = '{g: r_b_val, r: r_b_val, b: r_b_val};
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_v <= i_hsv.valid;
            end
            if (rdy_b) begin
                r_b_v <= r_a_v;
            end
            if (rdy_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_sec  <= sec;
            r_a_f    <= f_full[5:0];
            r_a_base <= base_full[15:8];
            r_a_val  <= i_hsv.brightness;
            r_a_grey <= (i_hsv.saturation == '0);
        end
        if (rdy_b) begin
            r_b_sec  <= r_a_sec;
            r_b_up   <= 14'(d) * 14'(r_a_f);
            r_b_dn   <= 14'(d) * 14'(SPAN - r_a_f);
            r_b_base <= r_a_base;
            r_b_val  <= r_a_val;
            r_b_grey <= r_a_grey;
        end
        if (rdy_c) begin
            r_c_grb <= grb;
        end
    end

endmodule

`default_nettype wire

### sv/hsvled_queue.sv
`default_nettype none

module hsvled_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  hsvled_pkg::t_grb  i_data,
    output logic              o_ready,
    input  wire               i_pop,
    output logic              o_valid,
    output hsvled_pkg::t_grb  o_data
);
    import hsvled_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_grb            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### sv/hsvled_back.sv
`default_nettype none

module hsvled_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  hsvled_pkg::t_grb       i_data,
    output logic                   o_pop,
    input  wire  [15:0]            i_one_duty,
    input  wire  [15:0]            i_zero_duty,
    hsvled_out_if.source           o_slot,
    output hsvled_pkg::t_back_stat o_stat
);
    import hsvled_pkg::*;

    logic [3*CH_W-1:0]  r_word;
    logic [SLOT_W-1:0]  r_cnt;
    logic               r_busy;
    logic               r_ovalid;
    logic [DUTY_W-1:0]  r_pw;
    logic               r_bit;
    logic               r_last;
    logic               adv, emit, last, pop;

    assign adv   = !r_ovalid || o_slot.ready;
    assign emit  = r_busy && adv;
    assign last  = (r_cnt == SLOT_W'(SLOTS - 1));
    assign pop   = i_valid && (!r_busy || (emit && last));
    assign o_pop = pop;

    assign o_slot.valid       = r_ovalid;
    assign o_slot.pulse_width = r_pw;
    assign o_slot.bit_value   = r_bit;
    assign o_slot.last_slot   = r_last;
    assign o_stat             = '{busy: r_busy, cnt: r_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (adv) begin
                r_ovalid <= 1'b0;
            end
            // a new word is loaded when idle, or takes over from the one just finished
            if (pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (emit) begin
                r_cnt <= last ? '0 : r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_bit  <= r_word[3*CH_W-1];
            r_pw   <= r_word[3*CH_W-1] ? i_one_duty : i_zero_duty;
            r_last <= last;
        end
        if (pop) begin
            r_word <= i_data;
        end else if (emit) begin
            r_word <= {r_word[3*CH_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

### sv/hsv_to_led_pulse_encoder_core.sv
`default_nettype none
// Channel   Dir  Beat carries                               Handshake
// i_hsv     in   hue[8:0], saturation[7:0], brightness[7:0]  valid/ready
// o_slot    out  pulse_width[15:0], bit_value, last_slot    valid/ready
// cfg       in   i_cfg_idx selects one_duty/zero_duty        i_cfg_we, no wait
//
// Each colour produces 24 output beats, one per cycle while o_slot is ready; the
// slot serialiser takes a new colour while it sends the last slot of the current one.
// On its way to the first slot a colour passes the three front stages, the queue,
// the word load and the output register.
// Reset is synchronous, active low; the duties clear to zero.
// A stalled output holds its beat; the queue lets the colour pipeline keep
// taking beats while the serialiser waits.

module hsv_to_led_pulse_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    hsvled_in_if.sink    i_hsv,
    hsvled_out_if.source o_slot,
    input  wire          i_cfg_we,
    input  wire  [0:0]   i_cfg_idx,
    input  wire  [15:0]  i_cfg_data
);
    import hsvled_pkg::*;

    logic [DUTY_W-1:0] r_one_duty;
    logic [DUTY_W-1:0] r_zero_duty;

    logic       f_valid;
    logic       q_ready;
    t_grb       f_grb;
    logic       q_valid;
    t_grb       q_data;
    logic       q_pop;
    t_back_stat b_stat;

    // Configuration: hold each duty until it is rewritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_duty  <= '0;
            r_zero_duty <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ONE_DUTY:  r_one_duty  <= i_cfg_data;
                REG_ZERO_DUTY: r_zero_duty <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: convert the colour to a G:R:B word in three stages
    hsvled_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hsv   (i_hsv),
        .o_valid (f_valid),
        .i_ready (q_ready),
        .o_grb   (f_grb)
    );

    // Decouple conversion from serialisation
    hsvled_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_grb),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Back: shift the word out MSB first, one slot per beat
    hsvled_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_data      (q_data),
        .o_pop       (q_pop),
        .i_one_duty  (r_one_duty),
        .i_zero_duty (r_zero_duty),
        .o_slot      (o_slot),
        .o_stat      (b_stat)
    );

    // An idle serialiser has its slot counter parked at zero
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !b_stat.busy |-> (b_stat.cnt == '0))
        else $error("slot counter not parked while idle");

    // The counter never runs past the last slot
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.cnt <= SLOT_W'(SLOTS - 1))
        else $error("slot counter out of range");

    // A flagged last slot means the counter has wrapped
    a_last_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_slot.valid && o_slot.last_slot) |-> (b_stat.cnt == '0))
        else $error("last slot shown without counter wrap");

endmodule

`default_nettype wire
